>>> rtl/streaming_token_lexer_macros.svh
// Assertion macros shared by the token lexer modules.
`ifndef STREAMING_TOKEN_LEXER_MACROS_SVH
`define STREAMING_TOKEN_LEXER_MACROS_SVH

`ifndef SYNTH
// Check that a property holds at every clock edge out of reset.
`define STL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("token lexer check failed");
// Check that a condition never comes true out of reset.
`define STL_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("token lexer check failed");
`else
`define STL_ASSERT(lbl, prop)
`define STL_NEVER(lbl, cond)
`endif

`endif

>>> rtl/stl_pkg.sv
// Shared types, codes and character tables of the streaming token lexer.
package stl_pkg;

  localparam int POS_WIDTH_DEF = 16;
  localparam int FIELD_W       = 16;
  localparam int KIND_W        = 5;
  localparam int MAX_TOK       = 3;
  localparam int QDEPTH        = 4;

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [7:0]         char_t;

  // Request kinds carried on the input tuser bit.
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Token kinds.
  localparam kind_t K_LBRACK  = 5'd0;
  localparam kind_t K_RBRACK  = 5'd1;
  localparam kind_t K_LPAREN  = 5'd2;
  localparam kind_t K_RPAREN  = 5'd3;
  localparam kind_t K_COLON   = 5'd4;
  localparam kind_t K_COMMA   = 5'd5;
  localparam kind_t K_DOT     = 5'd6;
  localparam kind_t K_SEMI    = 5'd7;
  localparam kind_t K_PLUS    = 5'd8;
  localparam kind_t K_STAR    = 5'd9;
  localparam kind_t K_PERCENT = 5'd10;
  localparam kind_t K_NE      = 5'd11;
  localparam kind_t K_BANG    = 5'd12;
  localparam kind_t K_EQEQ    = 5'd13;
  localparam kind_t K_ASSIGN  = 5'd14;
  localparam kind_t K_GE      = 5'd15;
  localparam kind_t K_GT      = 5'd16;
  localparam kind_t K_LE      = 5'd17;
  localparam kind_t K_LT      = 5'd18;
  localparam kind_t K_ARROW   = 5'd19;
  localparam kind_t K_MINUS   = 5'd20;
  localparam kind_t K_SLASH   = 5'd21;
  localparam kind_t K_STRING  = 5'd22;
  localparam kind_t K_NUMBER  = 5'd23;
  localparam kind_t K_END     = 5'd24;
  localparam kind_t K_UNTERM  = 5'd25;
  localparam kind_t K_INVALID = 5'd26;

  // Characters.
  localparam char_t CH_TAB     = 8'h09;
  localparam char_t CH_LF      = 8'h0A;
  localparam char_t CH_CR      = 8'h0D;
  localparam char_t CH_SPACE   = 8'h20;
  localparam char_t CH_BANG    = 8'h21;
  localparam char_t CH_QUOTE   = 8'h22;
  localparam char_t CH_PERCENT = 8'h25;
  localparam char_t CH_LPAREN  = 8'h28;
  localparam char_t CH_RPAREN  = 8'h29;
  localparam char_t CH_STAR    = 8'h2A;
  localparam char_t CH_PLUS    = 8'h2B;
  localparam char_t CH_COMMA   = 8'h2C;
  localparam char_t CH_MINUS   = 8'h2D;
  localparam char_t CH_DOT     = 8'h2E;
  localparam char_t CH_SLASH   = 8'h2F;
  localparam char_t CH_0       = 8'h30;
  localparam char_t CH_9       = 8'h39;
  localparam char_t CH_COLON   = 8'h3A;
  localparam char_t CH_SEMI    = 8'h3B;
  localparam char_t CH_LT      = 8'h3C;
  localparam char_t CH_EQ      = 8'h3D;
  localparam char_t CH_GT      = 8'h3E;
  localparam char_t CH_LBRACK  = 8'h5B;
  localparam char_t CH_RBRACK  = 8'h5D;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_OP,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_STRING,
    MODE_INT,
    MODE_DOT,
    MODE_FRAC,
    MODE_DEAD
  } mode_t;

  typedef struct packed {
    kind_t  kind;
    field_t start;
    field_t length;
    field_t line;
  } token_t;

  // All tokens that one request produces, slot 0 first.
  typedef struct packed {
    logic [1:0]                cnt;
    token_t [MAX_TOK-1:0]      tok;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } kind_hit_t;

  typedef struct packed {
    logic  hit;
    kind_t two;
    kind_t one;
  } op_info_t;

  function automatic kind_hit_t single_kind(char_t c);
    kind_hit_t r;
    r.hit = 1'b1;
    case (c)
      CH_LBRACK:  r.kind = K_LBRACK;
      CH_RBRACK:  r.kind = K_RBRACK;
      CH_LPAREN:  r.kind = K_LPAREN;
      CH_RPAREN:  r.kind = K_RPAREN;
      CH_COLON:   r.kind = K_COLON;
      CH_COMMA:   r.kind = K_COMMA;
      CH_DOT:     r.kind = K_DOT;
      CH_SEMI:    r.kind = K_SEMI;
      CH_PLUS:    r.kind = K_PLUS;
      CH_STAR:    r.kind = K_STAR;
      CH_PERCENT: r.kind = K_PERCENT;
      default: begin
        r.hit  = 1'b0;
        r.kind = K_INVALID;
      end
    endcase
    return r;
  endfunction

  // Operator starters: two-character kind and one-character fallback.
  function automatic op_info_t op_info(char_t c);
    op_info_t r;
    r.hit = 1'b1;
    case (c)
      CH_BANG: begin r.two = K_NE;    r.one = K_BANG;   end
      CH_EQ:   begin r.two = K_EQEQ;  r.one = K_ASSIGN; end
      CH_GT:   begin r.two = K_GE;    r.one = K_GT;     end
      CH_LT:   begin r.two = K_LE;    r.one = K_LT;     end
      CH_MINUS: begin r.two = K_ARROW; r.one = K_MINUS; end
      default: begin
        r.hit = 1'b0;
        r.two = K_ARROW;
        r.one = K_MINUS;
      end
    endcase
    return r;
  endfunction

  function automatic logic is_digit(char_t c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

endpackage

>>> rtl/stl_front.sv
// Scanner front end: accepts requests, runs the lexer state and bundles tokens.
`include "streaming_token_lexer_macros.svh"

module stl_front #(
  parameter int POS_WIDTH = stl_pkg::POS_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                cmd,
  input  stl_pkg::char_t      ch,
  input  stl_pkg::q_status_t  q_status,
  output logic                push,
  output stl_pkg::bundle_t    push_data
);

  typedef logic [POS_WIDTH-1:0] pos_t;

  stl_pkg::mode_t  mode, mode_next;
  stl_pkg::char_t  pending_char, pending_char_next;
  pos_t            position, position_next;
  pos_t            lexeme_start, lexeme_start_next;
  stl_pkg::field_t line_count, line_count_next;

  logic accept;

  pos_t pos_plus1, pos_minus1;
  stl_pkg::field_t len_run, len_dot, len_str, f_start, f_dot_start, f_pos;

  stl_pkg::kind_hit_t sk;
  stl_pkg::op_info_t  oc_in, oc_pend;
  stl_pkg::char_t     op_match;

  // Flush of the pending lexeme.
  logic [1:0]       f_cnt, fc;
  stl_pkg::token_t  f_tok0, f_tok1;

  // Fresh character seen from the idle mode.
  logic             id_emit, id_set_start, id_set_pend, id_line_inc;
  stl_pkg::mode_t   id_mode;
  stl_pkg::token_t  id_tok;

  logic             do_flush, use_idle, line_inc, tail_emit;
  stl_pkg::token_t  tail_tok;

  function automatic stl_pkg::token_t mk_tok(stl_pkg::kind_t k, stl_pkg::field_t s,
                                             stl_pkg::field_t n, stl_pkg::field_t l);
    stl_pkg::token_t t;
    t.kind   = k;
    t.start  = s;
    t.length = n;
    t.line   = l;
    return t;
  endfunction

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  assign pos_plus1   = position + pos_t'(1);
  assign pos_minus1  = position - pos_t'(1);
  assign len_run     = stl_pkg::field_t'(position - lexeme_start);
  assign len_dot     = stl_pkg::field_t'(pos_minus1 - lexeme_start);
  assign len_str     = stl_pkg::field_t'(pos_plus1 - lexeme_start);
  assign f_start     = stl_pkg::field_t'(lexeme_start);
  assign f_dot_start = stl_pkg::field_t'(pos_minus1);
  assign f_pos       = stl_pkg::field_t'(position);

  assign sk       = stl_pkg::single_kind(ch);
  assign oc_in    = stl_pkg::op_info(ch);
  assign oc_pend  = stl_pkg::op_info(pending_char);
  assign op_match = (pending_char == stl_pkg::CH_MINUS) ? stl_pkg::CH_GT : stl_pkg::CH_EQ;

  // Tokens that close the pending lexeme.
  always_comb begin
    f_cnt  = 2'd0;
    f_tok0 = mk_tok(stl_pkg::K_NUMBER, f_start, len_run, line_count);
    f_tok1 = mk_tok(stl_pkg::K_DOT, f_dot_start, stl_pkg::field_t'(1), line_count);
    case (mode)
      stl_pkg::MODE_OP: begin
        f_cnt  = 2'd1;
        f_tok0 = mk_tok(oc_pend.one, f_start, stl_pkg::field_t'(1), line_count);
      end
      stl_pkg::MODE_SLASH: begin
        f_cnt  = 2'd1;
        f_tok0 = mk_tok(stl_pkg::K_SLASH, f_start, stl_pkg::field_t'(1), line_count);
      end
      stl_pkg::MODE_INT, stl_pkg::MODE_FRAC: begin
        f_cnt = 2'd1;
      end
      stl_pkg::MODE_DOT: begin
        f_cnt  = 2'd2;
        f_tok0 = mk_tok(stl_pkg::K_NUMBER, f_start, len_dot, line_count);
      end
      stl_pkg::MODE_STRING: begin
        f_cnt  = 2'd1;
        f_tok0 = mk_tok(stl_pkg::K_UNTERM, f_start, len_run, line_count);
      end
      default: f_cnt = 2'd0;
    endcase
  end

  // Classify a character that starts from the idle mode.
  always_comb begin
    id_emit      = 1'b0;
    id_set_start = 1'b0;
    id_set_pend  = 1'b0;
    id_line_inc  = 1'b0;
    id_mode      = stl_pkg::MODE_IDLE;
    id_tok       = mk_tok(sk.kind, f_pos, stl_pkg::field_t'(1), line_count);
    if (sk.hit) begin
      id_emit = 1'b1;
    end else if (oc_in.hit) begin
      id_set_pend  = 1'b1;
      id_set_start = 1'b1;
      id_mode      = stl_pkg::MODE_OP;
    end else begin
      case (ch)
        stl_pkg::CH_SLASH: begin
          id_set_start = 1'b1;
          id_mode      = stl_pkg::MODE_SLASH;
        end
        stl_pkg::CH_SPACE, stl_pkg::CH_CR, stl_pkg::CH_TAB: id_mode = stl_pkg::MODE_IDLE;
        stl_pkg::CH_LF: id_line_inc = 1'b1;
        stl_pkg::CH_QUOTE: begin
          id_set_start = 1'b1;
          id_mode      = stl_pkg::MODE_STRING;
        end
        default: begin
          if (stl_pkg::is_digit(ch)) begin
            id_set_start = 1'b1;
            id_mode      = stl_pkg::MODE_INT;
          end else begin
            id_emit = 1'b1;
            id_mode = stl_pkg::MODE_DEAD;
          end
        end
      endcase
    end
  end

  // Next state and token bundle.
  always_comb begin
    mode_next         = mode;
    pending_char_next = pending_char;
    position_next     = position;
    lexeme_start_next = lexeme_start;
    line_count_next   = line_count;
    do_flush          = 1'b0;
    use_idle          = 1'b0;
    line_inc          = 1'b0;
    tail_emit         = 1'b0;
    tail_tok          = id_tok;
    if (accept) begin
      if (cmd == stl_pkg::CMD_END) begin
        do_flush          = 1'b1;
        tail_emit         = 1'b1;
        tail_tok          = mk_tok(stl_pkg::K_END, f_pos, '0, line_count);
        mode_next         = stl_pkg::MODE_IDLE;
        pending_char_next = '0;
        position_next     = '0;
        lexeme_start_next = '0;
        line_count_next   = stl_pkg::field_t'(1);
      end else begin
        position_next = pos_plus1;
        case (mode)
          stl_pkg::MODE_DEAD: use_idle = 1'b0;
          stl_pkg::MODE_COMMENT: use_idle = (ch == stl_pkg::CH_LF);
          stl_pkg::MODE_STRING: begin
            if (ch == stl_pkg::CH_QUOTE) begin
              tail_emit = 1'b1;
              tail_tok  = mk_tok(stl_pkg::K_STRING, f_start, len_str, line_count);
              mode_next = stl_pkg::MODE_IDLE;
            end else begin
              line_inc = (ch == stl_pkg::CH_LF);
            end
          end
          stl_pkg::MODE_OP: begin
            if (ch == op_match) begin
              tail_emit = 1'b1;
              tail_tok  = mk_tok(oc_pend.two, f_start, stl_pkg::field_t'(2), line_count);
              mode_next = stl_pkg::MODE_IDLE;
            end else begin
              do_flush = 1'b1;
              use_idle = 1'b1;
            end
          end
          stl_pkg::MODE_SLASH: begin
            if (ch == stl_pkg::CH_SLASH) begin
              mode_next = stl_pkg::MODE_COMMENT;
            end else begin
              do_flush = 1'b1;
              use_idle = 1'b1;
            end
          end
          stl_pkg::MODE_INT: begin
            if (ch == stl_pkg::CH_DOT) begin
              mode_next = stl_pkg::MODE_DOT;
            end else if (!stl_pkg::is_digit(ch)) begin
              do_flush = 1'b1;
              use_idle = 1'b1;
            end
          end
          stl_pkg::MODE_DOT: begin
            if (stl_pkg::is_digit(ch)) begin
              mode_next = stl_pkg::MODE_FRAC;
            end else begin
              do_flush = 1'b1;
              use_idle = 1'b1;
            end
          end
          stl_pkg::MODE_FRAC: begin
            if (!stl_pkg::is_digit(ch)) begin
              do_flush = 1'b1;
              use_idle = 1'b1;
            end
          end
          default: use_idle = 1'b1;
        endcase
        if (use_idle) begin
          tail_emit = id_emit;
          tail_tok  = id_tok;
          mode_next = id_mode;
          line_inc  = id_line_inc;
          if (id_set_start) begin
            lexeme_start_next = position;
          end
          if (id_set_pend) begin
            pending_char_next = ch;
          end
        end
        if (line_inc && (line_count != '1)) begin
          line_count_next = line_count + stl_pkg::field_t'(1);
        end
      end
    end
  end

  assign fc = do_flush ? f_cnt : 2'd0;

  always_comb begin
    push_data.cnt    = fc + {1'b0, tail_emit};
    push_data.tok[0] = (fc != 2'd0) ? f_tok0 : tail_tok;
    push_data.tok[1] = (fc == 2'd2) ? f_tok1 : tail_tok;
    push_data.tok[2] = tail_tok;
  end

  assign push = accept && (push_data.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= stl_pkg::MODE_IDLE;
      pending_char <= '0;
      position     <= '0;
      lexeme_start <= '0;
      line_count   <= stl_pkg::field_t'(1);
    end else begin
      mode         <= mode_next;
      pending_char <= pending_char_next;
      position     <= position_next;
      lexeme_start <= lexeme_start_next;
      line_count   <= line_count_next;
    end
  end

  `STL_NEVER(a_line_nonzero, line_count == '0)

endmodule

>>> rtl/stl_queue.sv
// Small bundle queue between the scanner and the token serializer.
`include "streaming_token_lexer_macros.svh"

module stl_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  stl_pkg::bundle_t    push_data,
  input  logic                pop,
  output stl_pkg::bundle_t    head,
  output stl_pkg::q_status_t  status
);

  localparam int PTR_W = $clog2(stl_pkg::QDEPTH);
  localparam int CNT_W = $clog2(stl_pkg::QDEPTH + 1);

  stl_pkg::bundle_t mem [stl_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(stl_pkg::QDEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign status.full  = (count == CNT_W'(stl_pkg::QDEPTH));
  assign status.empty = (count == '0);

  // Write on push; load the oldest bundle into the head register on pop.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (pop) begin
      head <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `STL_NEVER(a_no_overflow, push && status.full)
  `STL_NEVER(a_no_underflow, pop && status.empty)

endmodule

>>> rtl/stl_back.sv
// Token serializer: unpacks queued bundles to one token per cycle if ready.
`include "streaming_token_lexer_macros.svh"

module stl_back (
  input  logic                clk,
  input  logic                rst,
  input  stl_pkg::bundle_t    head,
  input  stl_pkg::q_status_t  q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output stl_pkg::token_t     out_token,
  output logic                out_last
);

  logic             cur_valid;
  logic [1:0]       idx;
  logic             at_last, done;

  // head is the bundle loaded by the last pop; serve it token by token.
  assign at_last   = (idx == (head.cnt - 2'd1));
  assign done      = out_ready && at_last;
  assign pop       = !q_status.empty && (!cur_valid || done);
  assign out_valid = cur_valid;
  assign out_token = head.tok[idx];
  assign out_last  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (cur_valid && out_ready) begin
      // Advance within the bundle, drop it after its last token.
      if (at_last) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  `STL_ASSERT(a_idx_in_bundle, cur_valid |-> (idx < head.cnt))

endmodule

>>> rtl/streaming_token_lexer.sv
// Top level of the streaming token lexer: scanner, bundle queue and serializer.
//
//  channel | dir | tdata                          | tuser      | tlast
//  s_axis  | in  | ch[7:0]                        | cmd        | -
//  m_axis  | out | start[15:0] length[31:16]      | token_kind | last_of_run
//          |     | line[47:32]                    |            |
//
// The scanner takes one request per cycle: its state step (mode, position, line
// count, one pending character) is registered on acceptance. A request yields
// zero to three tokens, pushed as one bundle into a four-entry queue; the bundle
// is loaded into the head register and sent one token per cycle while m_axis is ready.
// Requests stall only while the queue is full (sink throttling or runs of multi-token
// requests). Synchronous reset empties the queue and sets the scanner to line 1.
module streaming_token_lexer #(
  parameter int POS_WIDTH = stl_pkg::POS_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // ch[7:0]
  input  logic                         s_axis_tuser,   // cmd
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [3*stl_pkg::FIELD_W-1:0] m_axis_tdata,  // start, length, line (low first)
  output logic [stl_pkg::KIND_W-1:0]   m_axis_tuser,   // token_kind
  output logic                         m_axis_tlast    // last_of_run
);

  logic               push, pop;
  stl_pkg::bundle_t   push_data, head;
  stl_pkg::q_status_t q_status;
  stl_pkg::token_t    out_token;

  // Classify each request and bundle the tokens it closes.
  stl_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .cmd       (s_axis_tuser),
    .ch        (s_axis_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Hold bundles so the scanner and the sink stall independently.
  stl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // Hand out one token per cycle while ready, last_of_run on a bundle's final token.
  stl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_token (out_token),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_token.line, out_token.length, out_token.start};
  assign m_axis_tuser = out_token.kind;

endmodule

>>> dv/lexer_token_checker.sv
`timescale 1ns / 1ps
// Token checker for the streaming token lexer: predicts tokens from accepted requests, compares.
module lexer_token_checker
  import stl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // ch[7:0]
  input  logic                   s_axis_tuser,   // cmd
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [3*FIELD_W-1:0]   m_axis_tdata,   // start, length, line (low first)
  input  logic [KIND_W-1:0]      m_axis_tuser,   // token_kind
  input  logic                   m_axis_tlast,   // last_of_run
  output int                     fail_count,
  output int                     tokens_pending
);

  typedef struct {
    kind_t  kind;
    field_t start;
    field_t length;
    field_t line;
    logic   last;
  } tok_exp_t;

  tok_exp_t tokens_due[$];
  tok_exp_t step_tok[MAX_TOK];
  int       step_n;

  // Scanner state as the block should hold it.
  mode_t  scan;
  char_t  op_ch;
  field_t next_pos;
  field_t tok_from;
  field_t line_no;

  function automatic void restart_scan();
    scan     = MODE_IDLE;
    op_ch    = '0;
    next_pos = '0;
    tok_from = '0;
    line_no  = 16'd1;
  endfunction

  // Drop anything past three tokens, as the block does.
  function automatic void put_tok(kind_t k, field_t s, field_t n);
    if (step_n < MAX_TOK) begin
      step_tok[step_n].kind   = k;
      step_tok[step_n].start  = s;
      step_tok[step_n].length = n;
      step_tok[step_n].line   = line_no;
      step_tok[step_n].last   = 1'b0;
      step_n++;
    end
  endfunction

  function automatic int punct_kind(char_t c);
    case (c)
      CH_LBRACK:  return K_LBRACK;
      CH_RBRACK:  return K_RBRACK;
      CH_LPAREN:  return K_LPAREN;
      CH_RPAREN:  return K_RPAREN;
      CH_COLON:   return K_COLON;
      CH_COMMA:   return K_COMMA;
      CH_DOT:     return K_DOT;
      CH_SEMI:    return K_SEMI;
      CH_PLUS:    return K_PLUS;
      CH_STAR:    return K_STAR;
      CH_PERCENT: return K_PERCENT;
      default:    return -1;
    endcase
  endfunction

  // Two-character kind of an operator starter; the lone form is one above.
  function automatic int op_pair(char_t c);
    case (c)
      CH_BANG:  return K_NE;
      CH_EQ:    return K_EQEQ;
      CH_GT:    return K_GE;
      CH_LT:    return K_LE;
      CH_MINUS: return K_ARROW;
      default:  return -1;
    endcase
  endfunction

  function automatic logic is_num(char_t c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic void start_char(char_t c, field_t p);
    int k;
    int b;
    k = punct_kind(c);
    b = op_pair(c);
    scan = MODE_IDLE;
    if (k >= 0) begin
      put_tok(kind_t'(k), p, 16'd1);
    end else if (b >= 0) begin
      op_ch = c; tok_from = p; scan = MODE_OP;
    end else if (c == CH_SLASH) begin
      tok_from = p; scan = MODE_SLASH;
    end else if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
    end else if (c == CH_LF) begin
      if (line_no != 16'hFFFF) line_no = line_no + 16'd1;
    end else if (c == CH_QUOTE) begin
      tok_from = p; scan = MODE_STRING;
    end else if (is_num(c)) begin
      tok_from = p; scan = MODE_INT;
    end else begin
      put_tok(K_INVALID, p, 16'd1);
      scan = MODE_DEAD;
    end
  endfunction

  // Close whatever token is open when the character at p (or the end) arrives.
  function automatic void close_tok(field_t p);
    int b;
    case (scan)
      MODE_OP: begin
        b = op_pair(op_ch);
        if (b < 0) b = K_ARROW;
        put_tok(kind_t'(b + 1), tok_from, 16'd1);
      end
      MODE_SLASH: put_tok(K_SLASH, tok_from, 16'd1);
      MODE_INT, MODE_FRAC: put_tok(K_NUMBER, tok_from, field_t'(p - tok_from));
      MODE_DOT: begin
        put_tok(K_NUMBER, tok_from, field_t'(p - 16'd1 - tok_from));
        put_tok(K_DOT, field_t'(p - 16'd1), 16'd1);
      end
      default: ;
    endcase
    scan = MODE_IDLE;
  endfunction

  function automatic void lex_step(logic cmd, char_t c);
    field_t p;
    int     b;
    p      = next_pos;
    step_n = 0;
    if (cmd == CMD_END) begin
      if (scan == MODE_STRING) put_tok(K_UNTERM, tok_from, field_t'(p - tok_from));
      else close_tok(p);
      put_tok(K_END, p, 16'd0);
      restart_scan();
    end else begin
      next_pos = p + 16'd1;
      case (scan)
        MODE_DEAD: ;
        MODE_COMMENT: if (c == CH_LF) start_char(c, p);
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            put_tok(K_STRING, tok_from, field_t'(p + 16'd1 - tok_from));
            scan = MODE_IDLE;
          end else if (c == CH_LF && line_no != 16'hFFFF) begin
            line_no = line_no + 16'd1;
          end
        end
        MODE_OP: begin
          b = op_pair(op_ch);
          if (b < 0) b = K_ARROW;
          if (c == ((op_ch == CH_MINUS) ? CH_GT : CH_EQ)) begin
            put_tok(kind_t'(b), tok_from, 16'd2);
            scan = MODE_IDLE;
          end else begin
            close_tok(p); start_char(c, p);
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) scan = MODE_COMMENT;
          else begin close_tok(p); start_char(c, p); end
        end
        MODE_INT: begin
          if (is_num(c)) ;
          else if (c == CH_DOT) scan = MODE_DOT;
          else begin close_tok(p); start_char(c, p); end
        end
        MODE_DOT: begin
          if (is_num(c)) scan = MODE_FRAC;
          else begin close_tok(p); start_char(c, p); end
        end
        MODE_FRAC: begin
          if (!is_num(c)) begin close_tok(p); start_char(c, p); end
        end
        default: start_char(c, p);
      endcase
    end
    if (step_n > 0) step_tok[step_n-1].last = 1'b1;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    tok_exp_t want;
    if (rst) begin
      restart_scan();
      tokens_due.delete();
      fail_count = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        lex_step(s_axis_tuser, s_axis_tdata);
        for (int i = 0; i < step_n; i++) tokens_due.insert(tokens_due.size(), step_tok[i]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (tokens_due.size() == 0) begin
          $error("token_kind: expected none, got %0d", m_axis_tuser);
          fail_count++;
        end else begin
          want = tokens_due.pop_front();
          check_field("token_kind", want.kind, m_axis_tuser);
          check_field("token_start", want.start, m_axis_tdata[FIELD_W-1:0]);
          check_field("token_length", want.length, m_axis_tdata[2*FIELD_W-1:FIELD_W]);
          check_field("token_line", want.line, m_axis_tdata[3*FIELD_W-1:2*FIELD_W]);
          check_field("last_of_run", want.last, m_axis_tlast);
        end
      end
    end
    tokens_pending <= tokens_due.size();
  end

endmodule

>>> dv/tb_streaming_token_lexer.sv
`timescale 1ns / 1ps
// Testbench top for the streaming token lexer: clock, reset, request stimulus and verdict.
module tb_streaming_token_lexer;
  import stl_pkg::*;

  // Clock and the single reset at the start of the run.
  logic clk = 1'b0;
  logic rst = 1'b1;

  // Request side: every input starts at a known value.
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;   // ch[7:0]
  logic                 s_axis_tuser  = 1'b0; // cmd
  // Token side.
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [3*FIELD_W-1:0] m_axis_tdata;         // start, length, line (low first)
  logic [KIND_W-1:0]    m_axis_tuser;         // token_kind
  logic                 m_axis_tlast;         // last_of_run

  int   fail_count;
  int   tokens_pending;

  // Idle odds per cycle, in percent, for each side.
  int   src_idle_pct  = 32;
  int   sink_idle_pct = 58;
  // Requests that do real work; characters after an invalid byte are left out.
  int   live_items    = 0;
  logic dead_tail     = 1'b0;
  // One-cycle pulse that starts a long receiver hold-off.
  logic hold_trig     = 1'b0;
  int   hold_cnt      = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  streaming_token_lexer u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  lexer_token_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .fail_count     (fail_count),
    .tokens_pending (tokens_pending)
  );

  // Receiver: hold tready low for a counted stretch when asked, else
  // stall at random with the current odds.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
    end else if (hold_cnt != 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= hold_cnt - 1;
    end else if (hold_trig) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 200;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offer one request and hold it until accepted. Valid is lowered only
  // when a gap is taken, so it never drops and rises in the same step.
  task automatic send_req(input logic cmd, input char_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    if (!dead_tail) live_items++;
  endtask

  task automatic send_char(input char_t c);
    send_req(CMD_CHAR, c);
  endtask

  // The byte that rides with an end request is ignored; randomize it.
  task automatic send_end();
    send_req(CMD_END, char_t'($urandom_range(255)));
  endtask

  // Stop offering and wait until every predicted token has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (tokens_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic char_t punct_char();
    case ($urandom_range(10))
      0:       return CH_LBRACK;
      1:       return CH_RBRACK;
      2:       return CH_LPAREN;
      3:       return CH_RPAREN;
      4:       return CH_COLON;
      5:       return CH_COMMA;
      6:       return CH_DOT;
      7:       return CH_SEMI;
      8:       return CH_PLUS;
      9:       return CH_STAR;
      default: return CH_PERCENT;
    endcase
  endfunction

  function automatic char_t op_char();
    case ($urandom_range(4))
      0:       return CH_BANG;
      1:       return CH_EQ;
      2:       return CH_GT;
      3:       return CH_LT;
      default: return CH_MINUS;
    endcase
  endfunction

  function automatic char_t digit_char();
    return char_t'(CH_0 + $urandom_range(9));
  endfunction

  // Printable text for comments; never a newline.
  function automatic char_t comment_char();
    return char_t'($urandom_range(32, 126));
  endfunction

  // String body: printable, some newlines, never the closing quote.
  function automatic char_t text_char();
    char_t c;
    c = char_t'($urandom_range(32, 126));
    if ($urandom_range(7) == 0) c = CH_LF;
    if (c == CH_QUOTE) c = CH_SPACE;
    return c;
  endfunction

  // One lexeme-shaped piece of source with random content; a small share
  // is bare slashes, end requests and raw noise bytes.
  task automatic send_fragment();
    int    pick;
    int    n;
    char_t c;
    pick = $urandom_range(99);
    if (pick < 18) begin
      send_char(punct_char());
    end else if (pick < 36) begin
      c = op_char();
      send_char(c);
      if ($urandom_range(1) != 0) send_char((c == CH_MINUS) ? CH_GT : CH_EQ);
    end else if (pick < 54) begin
      n = $urandom_range(1, 4);
      repeat (n) send_char(digit_char());
      if ($urandom_range(2) != 0) begin
        // Zero fraction digits leaves a bare dot after the number.
        send_char(CH_DOT);
        n = $urandom_range(0, 3);
        repeat (n) send_char(digit_char());
      end
    end else if (pick < 66) begin
      send_char(CH_QUOTE);
      n = $urandom_range(0, 5);
      repeat (n) send_char(text_char());
      if ($urandom_range(7) != 0) send_char(CH_QUOTE);
    end else if (pick < 74) begin
      send_char(CH_SLASH);
      send_char(CH_SLASH);
      n = $urandom_range(0, 5);
      repeat (n) send_char(comment_char());
      send_char(CH_LF);
    end else if (pick < 80) begin
      send_char(CH_SLASH);
    end else if (pick < 92) begin
      case ($urandom_range(3))
        0:       send_char(CH_SPACE);
        1:       send_char(CH_TAB);
        2:       send_char(CH_CR);
        default: send_char(CH_LF);
      endcase
    end else if (pick < 96) begin
      send_end();
    end else begin
      // Raw byte, likely invalid; the scanner then drops input until the end.
      send_char(char_t'($urandom_range(255)));
      dead_tail = 1'b1;
      n = $urandom_range(0, 3);
      repeat (n) send_char(char_t'($urandom_range(255)));
      dead_tail = 1'b0;
      send_end();
    end
  endtask

  task automatic run_until(input int target);
    while (live_items < target) send_fragment();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed source: number closed by a bare dot and a semicolon
    // (three tokens from one request).
    send_char("7"); send_char(CH_DOT); send_char(CH_SEMI);
    // Two-character operators.
    send_char(CH_MINUS); send_char(CH_GT); send_char(CH_BANG); send_char(CH_EQ);
    // Comment up to the newline, which still counts a line.
    send_char(CH_SLASH); send_char(CH_SLASH); send_char("x"); send_char(CH_LF);
    // Operator closed by a newline keeps the line from before it.
    send_char(CH_LT); send_char(CH_LF);
    // String spanning a line, never closed: unterminated, then end.
    send_char(CH_QUOTE); send_char(CH_LF); send_end();
    // Lowest byte is invalid; the top byte after it is dropped.
    send_char(8'h00); send_char(8'hFF); send_end();
    // Top byte as the first character is invalid too.
    send_char(8'hFF); send_end();
    // Fractional number, then a slash flushed by the end request.
    send_char("2"); send_char(CH_DOT); send_char("5"); send_char(CH_SLASH);
    send_end();
    drain();

    // Random phase one: sender gaps light, receiver stalls heavy.
    src_idle_pct  = 32;
    sink_idle_pct = 58;
    run_until(130);
    drain();

    // Random phase two: the other way round.
    src_idle_pct  = 58;
    sink_idle_pct = 32;
    run_until(260);
    drain();

    // Random phase three: no idling, opened by a long receiver hold-off
    // while the sender keeps pushing until the block backs up.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_trig <= 1'b1;
    @(posedge clk);
    hold_trig <= 1'b0;
    run_until(390);
    send_end();
    s_axis_tvalid <= 1'b0;

    // Wait out every predicted token, then give stray output time to show.
    do @(posedge clk); while (tokens_pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: far past the slowest legal run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
